[hdl/scbs_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// scbs_pkg
// Shared widths, limits, codes and the command and status bundles that pass
// between the controller and the datapath of the cut block splitter.
// ============================================================================
package scbs_pkg;

    // Field widths.
    localparam int W_SHELL   = 10;
    localparam int W_ROW     = 10;
    localparam int W_ROW_END = 11;
    localparam int W_CFG     = 11;
    localparam int W_CFG_IDX = 1;
    localparam int W_LEN     = 11;
    localparam int W_SMALL   = 11;
    localparam int W_CNT     = 12;
    localparam int W_TOT     = 11;

    // Block pointer and extended row arithmetic.
    localparam int MAX_BLOCKS = 16;
    localparam int W_BLK      = $clog2(MAX_BLOCKS);
    localparam int W_EXT      = 15;

    localparam logic [W_BLK-1:0] LAST_BLOCK     = W_BLK'(MAX_BLOCKS - 1);
    localparam logic [W_BLK-1:0] NEXT_TO_LAST   = W_BLK'(MAX_BLOCKS - 2);

    // Register limits and reset values.
    localparam logic [W_CFG-1:0] MIN_ROWS      = 11'd1;
    localparam logic [W_CFG-1:0] MAX_ROWS      = 11'd1024;
    localparam logic [W_CFG-1:0] MIN_BLOCK     = 11'd64;
    localparam logic [W_CFG-1:0] MAX_BLOCK     = 11'd1024;
    localparam logic [W_CFG-1:0] RST_ROWS      = 11'd1024;
    localparam logic [W_CFG-1:0] RST_BLOCK     = 11'd64;
    localparam logic [W_TOT-1:0] SAT_TOTAL     = 11'd2047;

    // Register indexes.
    localparam logic [W_CFG_IDX-1:0] REG_MATRIX_ROWS = 1'b0;
    localparam logic [W_CFG_IDX-1:0] REG_BLOCK_SIZE  = 1'b1;

    // Result kinds.
    localparam logic KIND_PIECE  = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // capture an input transfer
        logic prep;       // recompute the block start from the pointer
        logic pull;       // step the pointer back by one block
        logic decide;     // load the open cut and update the run state
        logic load_last;  // load the final cut of the map
        logic cut;        // one step of the cut splitter (piece or marker)
        logic cut_mk;     // marker between two pieces of a split cut
        logic flush;      // marker for a block passed during the flush
        logic final_mk;   // final marker of the map, clears the map state
        logic tail_ok;    // results of this cut may end the item
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_last;      // captured item is the final shell
        logic close_first;  // the open run ends before this shell
        logic pull_more;    // pointer lies past the last block
        logic cut_done;     // cut ends without another result
        logic cut_piece;    // next cut step gives a piece
        logic cut_split;    // that piece continues into the next block
        logic at_last_blk;  // pointer is on the last block
        logic emit_ok;      // the output register can take a result
    } t_dp_stat;

endpackage

[hdl/submatrix_cut_block_splitter.sv]
`timescale 1ns / 1ps
// ============================================================================
// submatrix_cut_block_splitter
// An item is captured, the block start is set from the pointer, the pointer
// steps back block by block while it lies past the last block (after a block
// size change) and the run is decided; the results, the load of the final
// shell's cut and cut evaluations that end empty follow, and output stalls hold
// the sequencer. One result per cycle at most, set by the single result register.
// Reset is synchronous and active low; it loads the register reset values and clears the map state.
// ============================================================================
module submatrix_cut_block_splitter
    import scbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [W_CFG_IDX-1:0] i_cfg_index,
    input  logic [W_CFG-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [W_SHELL-1:0]   i_shell_index,
    input  logic [W_ROW-1:0]     i_row_start,
    input  logic [W_ROW_END-1:0] i_row_end,
    input  logic                 i_last_shell,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic [W_ROW-1:0]     o_big_start,
    output logic [W_LEN-1:0]     o_piece_length,
    output logic [W_SMALL-1:0]   o_small_start,
    output logic [W_BLK-1:0]     o_block_number,
    output logic [W_CNT-1:0]     o_piece_count,
    output logic                 o_last_of_run,
    output logic                 o_map_done
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    scbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath and result register.
    scbs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_shell_index  (i_shell_index),
        .i_row_start    (i_row_start),
        .i_row_end      (i_row_end),
        .i_last_shell   (i_last_shell),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_big_start    (o_big_start),
        .o_piece_length (o_piece_length),
        .o_small_start  (o_small_start),
        .o_block_number (o_block_number),
        .o_piece_count  (o_piece_count),
        .o_last_of_run  (o_last_of_run),
        .o_map_done     (o_map_done)
    );

endmodule

[hdl/scbs_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// scbs_ctrl
// Sequencer of the cut block splitter: takes one shell, steers the datapath
// through pointer setup, cut closing and the end-of-map flush.
// ============================================================================
module scbs_ctrl
    import scbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PREP   = 8'b0000_0010,
        S_PULL   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_LAST   = 8'b0001_0000,
        S_CUT    = 8'b0010_0000,
        S_CUT_MK = 8'b0100_0000,
        S_FLUSH  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_phase2;
    logic   n_phase2;
    t_state cut_exit;

    // Where a finished cut leads: the final cut goes on to the flush.
    always_comb begin
        if (r_phase2) begin
            cut_exit = S_FLUSH;
        end else if (i_stat.in_last) begin
            cut_exit = S_LAST;
        end else begin
            cut_exit = S_IDLE;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        n_phase2      = r_phase2;
        o_cmd         = '0;
        o_cmd.tail_ok = !r_phase2 && !i_stat.in_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_PULL;
            end
            S_PULL: begin
                if (i_stat.pull_more) begin
                    o_cmd.pull = 1'b1;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_phase2     = 1'b0;
                if (i_stat.close_first) begin
                    n_state = S_CUT;
                end else if (i_stat.in_last) begin
                    n_state = S_LAST;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LAST: begin
                o_cmd.load_last = 1'b1;
                n_phase2        = 1'b1;
                n_state         = S_CUT;
            end
            S_CUT: begin
                if (i_stat.cut_done) begin
                    n_state = cut_exit;
                end else if (i_stat.emit_ok) begin
                    o_cmd.cut = 1'b1;
                    if (i_stat.cut_split) begin
                        n_state = S_CUT_MK;
                    end else if (i_stat.cut_piece) begin
                        n_state = cut_exit;
                    end
                end
            end
            S_CUT_MK: begin
                if (i_stat.emit_ok) begin
                    o_cmd.cut_mk = 1'b1;
                    n_state      = S_CUT;
                end
            end
            S_FLUSH: begin
                if (i_stat.emit_ok) begin
                    if (!i_stat.at_last_blk) begin
                        o_cmd.flush = 1'b1;
                    end else begin
                        o_cmd.final_mk = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase2 <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase2 <= n_phase2;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    // A cut step is only issued when it gives a result that has room.
    a_cut_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cut |-> (!i_stat.cut_done && i_stat.emit_ok))
        else $error("cut step issued without a result or without room");

    // The flush never steps past the last block.
    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |-> !i_stat.at_last_blk)
        else $error("flush marker issued on the last block");

    // After the final marker the sequencer is ready for the next map.
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.final_mk |=> !o_in_stall)
        else $error("sequencer not idle after the final marker");
`endif

endmodule

[hdl/scbs_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// scbs_datapath
// Registers and arithmetic of the cut block splitter: configuration, run
// state, block pointer, cut bounds, counters and the result register.
// ============================================================================
module scbs_datapath
    import scbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [W_CFG_IDX-1:0] i_cfg_index,
    input  logic [W_CFG-1:0]     i_cfg_data,
    input  logic [W_SHELL-1:0]   i_shell_index,
    input  logic [W_ROW-1:0]     i_row_start,
    input  logic [W_ROW_END-1:0] i_row_end,
    input  logic                 i_last_shell,
    input  logic                 i_out_stall,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic                 o_out_valid,
    output logic                 o_kind,
    output logic [W_ROW-1:0]     o_big_start,
    output logic [W_LEN-1:0]     o_piece_length,
    output logic [W_SMALL-1:0]   o_small_start,
    output logic [W_BLK-1:0]     o_block_number,
    output logic [W_CNT-1:0]     o_piece_count,
    output logic                 o_last_of_run,
    output logic                 o_map_done
);

    // Configuration.
    logic [W_CFG-1:0]     r_matrix_rows;
    logic [W_CFG-1:0]     r_block_size;
    logic [W_CFG-1:0]     rows_eff;
    logic [W_CFG-1:0]     bsz_eff;

    // Captured input.
    logic [W_SHELL-1:0]   r_in_shell;
    logic [W_ROW-1:0]     r_in_rs;
    logic [W_ROW_END-1:0] r_in_re;
    logic                 r_in_last;

    // Map state.
    logic [W_ROW-1:0]     r_run_start;
    logic [W_SHELL-1:0]   r_prev_shell;
    logic [W_ROW_END-1:0] r_prev_end;
    logic                 r_run_open;
    logic [W_BLK-1:0]     r_cb;
    logic [W_SMALL-1:0]   r_small;
    logic [W_TOT-1:0]     r_pieces;
    logic [W_EXT-1:0]     r_bs;

    // Cut being closed.
    logic [W_EXT-1:0]     r_s;
    logic [W_ROW_END-1:0] r_e;

    // Result register.
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [W_ROW-1:0]     r_out_big;
    logic [W_LEN-1:0]     r_out_len;
    logic [W_SMALL-1:0]   r_out_small;
    logic [W_BLK-1:0]     r_out_blk;
    logic [W_CNT-1:0]     r_out_cnt;
    logic                 r_out_last;
    logic                 r_out_done;

    logic                 n_out_kind;
    logic [W_ROW-1:0]     n_out_big;
    logic [W_LEN-1:0]     n_out_len;
    logic [W_SMALL-1:0]   n_out_small;
    logic [W_CNT-1:0]     n_out_cnt;
    logic                 n_out_last;
    logic                 n_out_done;

    // Working values.
    logic [W_EXT-1:0]     rows_ext;
    logic [W_EXT-1:0]     bsz_ext;
    logic [W_EXT-1:0]     e_ext;
    logic [W_EXT-1:0]     be;
    logic [W_EXT-1:0]     be2;
    logic [W_EXT-1:0]     prod;
    logic [W_EXT-1:0]     ps;
    logic [W_EXT-1:0]     pe;
    logic [W_EXT-1:0]     len;
    logic [W_SMALL:0]     small_sum;
    logic                 lastblk;
    logic                 s_past;
    logic                 before_blk;
    logic                 mk_last;
    logic                 consec;
    logic                 emit;
    logic                 block_step;

    // Register values clamped to their legal ranges.
    always_comb begin
        if (r_matrix_rows < MIN_ROWS) begin
            rows_eff = MIN_ROWS;
        end else if (r_matrix_rows > MAX_ROWS) begin
            rows_eff = MAX_ROWS;
        end else begin
            rows_eff = r_matrix_rows;
        end
        if (r_block_size < MIN_BLOCK) begin
            bsz_eff = MIN_BLOCK;
        end else if (r_block_size > MAX_BLOCK) begin
            bsz_eff = MAX_BLOCK;
        end else begin
            bsz_eff = r_block_size;
        end
    end

    assign rows_ext = W_EXT'(rows_eff);
    assign bsz_ext  = W_EXT'(bsz_eff);
    assign e_ext    = W_EXT'(r_e);

    // Block bounds; the pointer is on the last block when it points at LAST_BLOCK
    // or when the next block would start at or past the row count.
    assign be      = r_bs + bsz_ext;
    assign be2     = be + bsz_ext;
    assign prod    = W_EXT'(r_cb) * bsz_ext;
    assign lastblk = (r_cb == LAST_BLOCK) || (be >= rows_ext);

    // Classification of the next cut step.
    assign s_past     = (r_s >= be);
    assign before_blk = (r_s < r_bs) && (e_ext < r_bs);
    assign mk_last    = (r_s >= be2) && ((r_cb == NEXT_TO_LAST) || (be2 >= rows_ext));

    // Piece bounds clipped to the current block.
    assign ps        = (r_s < r_bs) ? r_bs : r_s;
    assign pe        = (e_ext < be) ? e_ext : be;
    assign len       = (pe > ps) ? (pe - ps) : '0;
    assign small_sum = {1'b0, r_small} + (W_SMALL + 1)'(len);

    assign consec = ({1'b0, r_in_shell} == ({1'b0, r_prev_shell} + (W_SHELL + 1)'(1)));

    // Status toward the controller.
    always_comb begin
        o_stat.in_last     = r_in_last;
        o_stat.close_first = r_run_open && !consec;
        o_stat.pull_more   = (r_cb != '0) && (r_bs >= rows_ext);
        o_stat.cut_done    = (s_past && lastblk) || (!s_past && before_blk);
        o_stat.cut_piece   = !s_past && !before_blk;
        o_stat.cut_split   = !s_past && !before_blk && (e_ext > be) && !lastblk;
        o_stat.at_last_blk = lastblk;
        o_stat.emit_ok     = !r_out_valid || !i_out_stall;
    end

    assign emit       = i_cmd.cut || i_cmd.cut_mk || i_cmd.flush || i_cmd.final_mk;
    assign block_step = (i_cmd.cut && s_past) || i_cmd.cut_mk || i_cmd.flush;

    // Fields of the result produced in this cycle.
    always_comb begin
        n_out_kind  = KIND_MARKER;
        n_out_big   = '0;
        n_out_len   = '0;
        n_out_small = '0;
        n_out_cnt   = W_CNT'(r_pieces);
        n_out_last  = 1'b0;
        n_out_done  = 1'b0;
        if (i_cmd.cut && !s_past) begin
            n_out_kind  = KIND_PIECE;
            n_out_big   = ps[W_ROW-1:0];
            n_out_len   = len[W_LEN-1:0];
            n_out_small = r_small;
            n_out_cnt   = '0;
            n_out_last  = i_cmd.tail_ok && !o_stat.cut_split;
        end else if (i_cmd.cut) begin
            n_out_last = i_cmd.tail_ok && mk_last;
        end else if (i_cmd.final_mk) begin
            n_out_last = 1'b1;
            n_out_done = 1'b1;
        end
    end

    // Configuration, map state, pointer and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_rows <= RST_ROWS;
            r_block_size  <= RST_BLOCK;
            r_run_start   <= '0;
            r_prev_shell  <= '0;
            r_prev_end    <= '0;
            r_run_open    <= 1'b0;
            r_cb          <= '0;
            r_small       <= '0;
            r_pieces      <= '0;
            r_bs          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MATRIX_ROWS: r_matrix_rows <= i_cfg_data;
                    REG_BLOCK_SIZE:  r_block_size  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // Block pointer and block start.
            if (i_cmd.prep) begin
                r_bs <= prod;
            end else if (i_cmd.pull) begin
                r_cb <= r_cb - W_BLK'(1);
                r_bs <= r_bs - bsz_ext;
            end else if (block_step) begin
                r_cb <= r_cb + W_BLK'(1);
                r_bs <= be;
            end

            // Run tracking.
            if (i_cmd.decide) begin
                if (!(r_run_open && consec)) begin
                    r_run_start <= r_in_rs;
                    r_run_open  <= 1'b1;
                end
                r_prev_shell <= r_in_shell;
                r_prev_end   <= r_in_re;
            end

            // Packed row total and piece count, both saturating.
            if (i_cmd.cut && !s_past) begin
                r_small <= (small_sum > {1'b0, SAT_TOTAL}) ? SAT_TOTAL
                                                           : small_sum[W_SMALL-1:0];
                if (r_pieces < SAT_TOTAL) begin
                    r_pieces <= r_pieces + W_TOT'(1);
                end
            end

            // End of map: map state and pointer back to their starting point.
            if (i_cmd.final_mk) begin
                r_run_start  <= '0;
                r_prev_shell <= '0;
                r_prev_end   <= '0;
                r_run_open   <= 1'b0;
                r_cb         <= '0;
                r_small      <= '0;
                r_pieces     <= '0;
                r_bs         <= '0;
            end

            // Result register: filled by an emission, freed by a transfer.
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_shell <= i_shell_index;
            r_in_rs    <= i_row_start;
            r_in_re    <= i_row_end;
            r_in_last  <= i_last_shell;
        end
        if (i_cmd.decide || i_cmd.load_last) begin
            r_s <= W_EXT'(r_run_start);
            r_e <= r_prev_end;
        end else if (i_cmd.cut_mk) begin
            r_s <= be;
        end
        if (emit) begin
            r_out_kind  <= n_out_kind;
            r_out_big   <= n_out_big;
            r_out_len   <= n_out_len;
            r_out_small <= n_out_small;
            r_out_blk   <= r_cb;
            r_out_cnt   <= n_out_cnt;
            r_out_last  <= n_out_last;
            r_out_done  <= n_out_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_big_start    = r_out_big;
    assign o_piece_length = r_out_len;
    assign o_small_start  = r_out_small;
    assign o_block_number = r_out_blk;
    assign o_piece_count  = r_out_cnt;
    assign o_last_of_run  = r_out_last;
    assign o_map_done     = r_out_done;

`ifndef NO_ASSERTIONS
    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // A piece never spans more than one block.
    a_piece_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_PIECE)) |-> (r_out_len <= bsz_eff))
        else $error("piece longer than a block");

    // The final marker leaves the map state cleared.
    a_map_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.final_mk |=> (!r_run_open && (r_cb == '0) && (r_pieces == '0)
                            && (r_small == '0)))
        else $error("map state not cleared after the final marker");
`endif

endmodule
